### hw/rtl/revolver_thread_scheduler_assert.svh
// Assertion macros used by the checker file of the thread scheduler.
// Both sample on the rising edge of clock and stay quiet while reset is high.
`ifndef REVOLVER_THREAD_SCHEDULER_ASSERT_SVH
`define REVOLVER_THREAD_SCHEDULER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RVS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RVS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/rvs_pkg.sv
// ---------------------------------------------------------------------------
// rvs_pkg
// Types and constants of the revolver thread scheduler: thread modes, action
// codes, idle causes, payload structs and controller commands.
// ---------------------------------------------------------------------------
package rvs_pkg;

   localparam int NUM_THREADS = 16;
   localparam int GAP_BITS    = 8;

   localparam int ID_W   = 4;
   localparam int CNT_W  = 5;
   localparam int GAP_W  = 8;
   localparam int CMP_W  = (GAP_BITS > GAP_W) ? GAP_BITS : GAP_W;

   localparam logic [GAP_W-1:0] GAP_RESET = 8'd11;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_GAP_ADDR = 2'd0;

   localparam logic [1:0] CAUSE_NONE    = 2'd0;
   localparam logic [1:0] CAUSE_BLOCKED = 2'd1;
   localparam logic [1:0] CAUSE_OTHER   = 2'd2;

   typedef enum logic [2:0] {
      ACT_SCHEDULE = 3'd0,
      ACT_TICK     = 3'd1,
      ACT_BOOT     = 3'd2,
      ACT_SLEEP    = 3'd3,
      ACT_BLOCK    = 3'd4,
      ACT_AWAKE    = 3'd5,
      ACT_SHUTDOWN = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      MODE_EMBRYO   = 3'd0,
      MODE_RUNNABLE = 3'd1,
      MODE_SLEEP    = 3'd2,
      MODE_BLOCK    = 3'd3,
      MODE_ZOMBIE   = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_HOLD
   } ctrl_state_type;

   typedef struct packed {
      logic [2:0]      action;
      logic [ID_W-1:0] thread_id;
   } req_type;

   typedef struct packed {
      logic             grant_valid;
      logic [ID_W-1:0]  grant_thread;
      logic [1:0]       idle_cause;
      logic             bad_transition;
      logic [CNT_W-1:0] runnable_count;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
   } dp_cmd_type;

endpackage

### hw/rtl/revolver_thread_scheduler.sv
// ---------------------------------------------------------------------------
// revolver_thread_scheduler
// Round-robin issue scheduler for up to 16 hardware threads.
// ---------------------------------------------------------------------------
// Each accepted item gives exactly one result item. An item is taken in one
// cycle, executed against the thread table in the next, and its result is
// shown from the cycle after that until taken, set by the controller's
// capture, execute and present sequence. The block takes no new item while
// an item is executed or while its result is waiting.
// The gap register sits at address 0; writes are taken at any time.
module revolver_thread_scheduler (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  rvs_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output rvs_pkg::rsp_type                 rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [rvs_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [rvs_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [rvs_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                             pready
);

   rvs_pkg::dp_cmd_type       cmd;
   logic                      gap_wr;
   logic [rvs_pkg::GAP_W-1:0] gap;

   assign pready = 1'b1;
   assign gap_wr = psel && penable && pwrite && (paddr == rvs_pkg::CSR_GAP_ADDR);
   assign prdata = (paddr == rvs_pkg::CSR_GAP_ADDR) ? rvs_pkg::CSR_DATA_W'(gap) : '0;

   rvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   rvs_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .gap_wr    (gap_wr),
      .gap_wdata (pwdata[rvs_pkg::GAP_W-1:0]),
      .gap       (gap),
      .rsp_data  (rsp_data)
   );

endmodule

### hw/rtl/rvs_ctrl.sv
// ---------------------------------------------------------------------------
// rvs_ctrl
// Controller: takes one item, has the datapath execute it, then presents the
// result until the consumer takes it.
// ---------------------------------------------------------------------------
module rvs_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rvs_pkg::dp_cmd_type cmd
);

   rvs_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rvs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      cmd.capture = 1'b0;
      cmd.execute = 1'b0;
      unique case (state_ff)
         rvs_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = rvs_pkg::ST_EXEC;
            end
         end
         rvs_pkg::ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = rvs_pkg::ST_HOLD;
         end
         rvs_pkg::ST_HOLD: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = rvs_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rvs_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

### hw/rtl/rvs_dp.sv
// ---------------------------------------------------------------------------
// rvs_dp
// Datapath: thread modes, issue counters, rotation pointer, gap register,
// runnable count, and the round-robin pick over eligible threads.
// ---------------------------------------------------------------------------
module rvs_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  rvs_pkg::dp_cmd_type           cmd,
   input  rvs_pkg::req_type              req_data,
   input  logic                          gap_wr,
   input  logic [rvs_pkg::GAP_W-1:0]     gap_wdata,
   output logic [rvs_pkg::GAP_W-1:0]     gap,
   output rvs_pkg::rsp_type              rsp_data
);

   localparam int N    = rvs_pkg::NUM_THREADS;
   localparam int ID_W = rvs_pkg::ID_W;

   rvs_pkg::mode_type            mode_ff  [N];
   rvs_pkg::mode_type            mode_in  [N];
   logic [rvs_pkg::GAP_BITS-1:0] since_ff [N];
   logic [rvs_pkg::GAP_BITS-1:0] since_in [N];
   logic [ID_W-1:0]              start_ff, start_in;
   logic [rvs_pkg::GAP_W-1:0]    gap_ff;
   logic [rvs_pkg::CNT_W-1:0]    run_cnt_ff, run_cnt_in;
   rvs_pkg::req_type             item_ff;
   rvs_pkg::rsp_type             rsp_ff, rsp_in;

   logic [N-1:0]    ready_vec;
   logic [N-1:0]    blk_vec;
   logic [2*N-1:0]  ready_dbl;
   logic [N-1:0]    window;
   logic            found;
   logic [ID_W-1:0] offset;
   logic [ID_W:0]   pick_sum;
   logic [ID_W-1:0] pick_idx;
   logic [ID_W:0]   pick_inc;

   logic              in_range;
   rvs_pkg::mode_type cur_mode, new_mode;
   logic              legal;

   // eligibility of each thread
   always_comb begin
      for (int i = 0; i < N; i++) begin
         ready_vec[i] = (rvs_pkg::CMP_W'(since_ff[i]) >= rvs_pkg::CMP_W'(gap_ff))
                        && (mode_ff[i] == rvs_pkg::MODE_RUNNABLE);
         blk_vec[i]   = (rvs_pkg::CMP_W'(since_ff[i]) >= rvs_pkg::CMP_W'(gap_ff))
                        && (mode_ff[i] == rvs_pkg::MODE_BLOCK);
      end
   end

   // rotate so the scan starts at the pointer, then take the lowest hit
   assign ready_dbl = {ready_vec, ready_vec};
   assign window    = N'(ready_dbl >> start_ff);

   always_comb begin
      found  = 1'b0;
      offset = '0;
      for (int k = 0; k < N; k++) begin
         if (window[k] && !found) begin
            found  = 1'b1;
            offset = ID_W'(k);
         end
      end
   end

   always_comb begin
      pick_sum = {1'b0, start_ff} + {1'b0, offset};
      if (pick_sum >= (ID_W+1)'(N)) begin
         pick_sum = pick_sum - (ID_W+1)'(N);
      end
      pick_idx = pick_sum[ID_W-1:0];
      pick_inc = {1'b0, pick_idx} + (ID_W+1)'(1);
      if (pick_inc == (ID_W+1)'(N)) begin
         pick_inc = '0;
      end
   end

   // mode change legality
   assign in_range = {1'b0, item_ff.thread_id} < (ID_W+1)'(N);
   assign cur_mode = in_range ? mode_ff[item_ff.thread_id] : rvs_pkg::MODE_EMBRYO;

   always_comb begin
      legal    = 1'b0;
      new_mode = cur_mode;
      case (item_ff.action)
         rvs_pkg::ACT_BOOT: begin
            legal    = (cur_mode == rvs_pkg::MODE_EMBRYO) ||
                       (cur_mode == rvs_pkg::MODE_ZOMBIE);
            new_mode = rvs_pkg::MODE_RUNNABLE;
         end
         rvs_pkg::ACT_SLEEP: begin
            legal    = (cur_mode == rvs_pkg::MODE_RUNNABLE);
            new_mode = rvs_pkg::MODE_SLEEP;
         end
         rvs_pkg::ACT_BLOCK: begin
            legal    = (cur_mode == rvs_pkg::MODE_RUNNABLE);
            new_mode = rvs_pkg::MODE_BLOCK;
         end
         rvs_pkg::ACT_AWAKE: begin
            legal    = (cur_mode == rvs_pkg::MODE_EMBRYO) ||
                       (cur_mode == rvs_pkg::MODE_SLEEP) ||
                       (cur_mode == rvs_pkg::MODE_BLOCK);
            new_mode = rvs_pkg::MODE_RUNNABLE;
         end
         rvs_pkg::ACT_SHUTDOWN: begin
            legal    = (cur_mode == rvs_pkg::MODE_SLEEP);
            new_mode = rvs_pkg::MODE_ZOMBIE;
         end
         default: begin
            legal = 1'b0;
         end
      endcase
      legal = legal && in_range;
   end

   // next state and result of the held item
   always_comb begin
      for (int i = 0; i < N; i++) begin
         mode_in[i]  = mode_ff[i];
         since_in[i] = since_ff[i];
      end
      start_in   = start_ff;
      run_cnt_in = run_cnt_ff;
      rsp_in     = '0;
      case (item_ff.action)
         rvs_pkg::ACT_SCHEDULE: begin
            if (found) begin
               since_in[pick_idx] = '0;
               start_in           = pick_inc[ID_W-1:0];
               rsp_in.grant_valid  = 1'b1;
               rsp_in.grant_thread = pick_idx;
               rsp_in.idle_cause   = rvs_pkg::CAUSE_NONE;
            end else begin
               rsp_in.idle_cause = (|blk_vec) ? rvs_pkg::CAUSE_BLOCKED
                                              : rvs_pkg::CAUSE_OTHER;
            end
         end
         rvs_pkg::ACT_TICK: begin
            for (int i = 0; i < N; i++) begin
               if (since_ff[i] != '1) begin
                  since_in[i] = since_ff[i] + rvs_pkg::GAP_BITS'(1);
               end
            end
         end
         rvs_pkg::ACT_BOOT, rvs_pkg::ACT_SLEEP, rvs_pkg::ACT_BLOCK,
         rvs_pkg::ACT_AWAKE, rvs_pkg::ACT_SHUTDOWN: begin
            rsp_in.bad_transition = !legal;
            if (legal) begin
               mode_in[item_ff.thread_id] = new_mode;
               // track runnable count as threads enter and leave the mode
               if (new_mode == rvs_pkg::MODE_RUNNABLE) begin
                  run_cnt_in = run_cnt_ff + rvs_pkg::CNT_W'(1);
               end else if (cur_mode == rvs_pkg::MODE_RUNNABLE) begin
                  run_cnt_in = run_cnt_ff - rvs_pkg::CNT_W'(1);
               end
            end
         end
         default: begin
            rsp_in = '0;
         end
      endcase
      rsp_in.runnable_count = run_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            mode_ff[i]  <= rvs_pkg::MODE_EMBRYO;
            since_ff[i] <= '0;
         end
         start_ff   <= '0;
         run_cnt_ff <= '0;
         gap_ff     <= rvs_pkg::GAP_RESET;
      end else begin
         if (cmd.execute) begin
            for (int i = 0; i < N; i++) begin
               mode_ff[i]  <= mode_in[i];
               since_ff[i] <= since_in[i];
            end
            start_ff   <= start_in;
            run_cnt_ff <= run_cnt_in;
         end
         if (gap_wr) begin
            gap_ff <= gap_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_data;
      end
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign gap      = gap_ff;
   assign rsp_data = rsp_ff;

endmodule

### hw/rtl/rvs_checker.sv
// ---------------------------------------------------------------------------
// rvs_checker
// Port-level checks of the thread scheduler, bound to the top level.
// ---------------------------------------------------------------------------
`include "revolver_thread_scheduler_assert.svh"

module rvs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input rvs_pkg::rsp_type               rsp_data
);

   `RVS_ASSERT_SAME(a_grant_clean, rsp_valid && rsp_data.grant_valid, (rsp_data.idle_cause == rvs_pkg::CAUSE_NONE) && !rsp_data.bad_transition, "grant with idle cause or error")
   `RVS_ASSERT_SAME(a_no_grant_zero, rsp_valid && !rsp_data.grant_valid, rsp_data.grant_thread == '0, "thread id without grant")
   `RVS_ASSERT_SAME(a_count_range, rsp_valid, {27'd0, rsp_data.runnable_count} <= rvs_pkg::NUM_THREADS, "runnable count out of range")
   `RVS_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "second item taken while busy")
   `RVS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind revolver_thread_scheduler rvs_checker u_rvs_checker (.*);
